@@ hw/rtl/pobp_pkg.sv @@
// shared constants and types for the pairwise overlap best pair block
package pobp_pkg;
  localparam int MAX_WORDS_DEF = 16;
  localparam int MAX_LEN_DEF = 32;
  localparam int SYM_W = 8;
  localparam int OVL_W = 6;
  localparam int IDX_W = 4;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_PAIR  = 6'b000010,
    ST_KSET  = 6'b000100,
    ST_RDREQ = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;
endpackage

@@ hw/rtl/pairwise_overlap_best_pair_top.sv @@
// top level: word loader, overlap search sequencer and character memory
//
// Characters load one per cycle (busy low) into a single-port-write,
// dual-port-read character memory. The transaction carrying end_of_set starts
// the search and raises busy. Each ordered pair of distinct words first passes the
// setup states: the pair step, which also reads both word lengths, and the
// length set. A pair of equal indexes is skipped in the pair step. Each
// candidate overlap k, from the shorter length L down to 1, is then checked
// one character at a time, by a registered memory read and a compare. When
// no candidate matches, the pair settles with an overlap of zero. After the
// last pair the done state forms the result, which is shown for one cycle on
// out_valid while busy is low again. The receiver cannot stall it. The store
// needs no clearing: word count and lengths restart for each set.
module pairwise_overlap_best_pair_top #(
  parameter int MAX_WORDS = pobp_pkg::MAX_WORDS_DEF,
  parameter int MAX_LEN = pobp_pkg::MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [pobp_pkg::SYM_W-1:0] in_symbol,
  input  logic in_end_of_word,
  input  logic in_end_of_set,
  output logic out_valid,
  output logic [pobp_pkg::OVL_W-1:0] out_best_overlap,
  output logic [pobp_pkg::IDX_W-1:0] out_first_word,
  output logic [pobp_pkg::IDX_W-1:0] out_second_word,
  output logic out_pair_found,
  output logic out_overflow
);
  localparam int WW = $clog2(MAX_WORDS);
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = WW + PW;
  localparam int DEPTH = MAX_WORDS * (1 << PW);

  pobp_pkg::state_t state_r, state_nxt;

  logic [pobp_pkg::SYM_W-1:0] mem [DEPTH];
  logic [LW-1:0] len_mem [MAX_WORDS];
  logic [CW-1:0] count_r;
  logic [LW-1:0] pos_r;
  logic ovf_r;

  logic [WW-1:0] i_r, j_r;
  logic [LW-1:0] k_r, t_r, li_r;
  logic [LW:0] best_r;     // best overlap so far, valid once best_none_r is low
  logic best_none_r;
  logic [WW-1:0] bi_r, bj_r;
  logic [pobp_pkg::SYM_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0] addr_a, addr_b;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != pobp_pkg::ST_LOAD);

  // write path of the character memory
  assign wr_en = accept && (count_r < CW'(MAX_WORDS)) && (pos_r < LW'(MAX_LEN));
  assign wr_addr = {count_r[WW-1:0], pos_r[PW-1:0]};

  // read addresses: suffix char of word i, prefix char of word j
  logic [LW-1:0] a_off;
  assign a_off = li_r - k_r + t_r;
  assign addr_a = {i_r, a_off[PW-1:0]};
  assign addr_b = {j_r, t_r[PW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_symbol;
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // word lengths in a small store with registered reads at the pair's indexes
  logic len_wr;
  logic [LW-1:0] len_val;
  logic [LW-1:0] len_i_r, len_j_r;
  assign len_wr = accept && (in_end_of_word || in_end_of_set) && (count_r < CW'(MAX_WORDS));
  assign len_val = wr_en ? pos_r + LW'(1) : pos_r;
  always_ff @(posedge clk) begin
    if (len_wr) len_mem[count_r[WW-1:0]] <= len_val;
    len_i_r <= len_mem[i_r];
    len_j_r <= len_mem[j_r];
  end

  logic last_j, last_i;
  assign last_j = (CW'(j_r) == count_r - CW'(1));
  assign last_i = (CW'(i_r) == count_r - CW'(1));

  // overlap of the current pair is settled in the compare cycle
  logic ovl_settled;
  assign ovl_settled = (k_r == '0) || (rd_a_r == rd_b_r && t_r + LW'(1) == k_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pobp_pkg::ST_LOAD:  if (accept && in_end_of_set) state_nxt = pobp_pkg::ST_PAIR;
      pobp_pkg::ST_PAIR:  begin
        if (count_r < CW'(2)) state_nxt = pobp_pkg::ST_DONE;
        else if (i_r != j_r) state_nxt = pobp_pkg::ST_KSET;
        else if (last_i && last_j) state_nxt = pobp_pkg::ST_DONE;
        else state_nxt = pobp_pkg::ST_PAIR;
      end
      pobp_pkg::ST_KSET:  state_nxt = pobp_pkg::ST_RDREQ;
      pobp_pkg::ST_RDREQ: state_nxt = pobp_pkg::ST_CMP;
      pobp_pkg::ST_CMP:   begin
        if (!ovl_settled) state_nxt = pobp_pkg::ST_RDREQ;
        else if (last_i && last_j) state_nxt = pobp_pkg::ST_DONE;
        else state_nxt = pobp_pkg::ST_PAIR;
      end
      pobp_pkg::ST_DONE:  state_nxt = pobp_pkg::ST_LOAD;
      default:            state_nxt = pobp_pkg::ST_LOAD;
    endcase
  end

  // sequencer: loading, pair walk, overlap compare and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pobp_pkg::ST_LOAD;
      count_r <= '0;
      pos_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      i_r <= '0;
      j_r <= '0;
      best_none_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      case (state_r)
        pobp_pkg::ST_LOAD: begin
          if (accept) begin
            if (in_end_of_word || in_end_of_set) pos_r <= '0;
            else if (wr_en) pos_r <= pos_r + LW'(1);
            if (!wr_en) ovf_r <= 1'b1;
            if (len_wr) count_r <= count_r + CW'(1);
            i_r <= '0;
            j_r <= '0;
            best_none_r <= 1'b1;
            best_r <= '0;
            bi_r <= '0;
            bj_r <= '0;
          end
        end
        pobp_pkg::ST_PAIR: begin
          // skip the diagonal
          if (count_r >= CW'(2) && i_r == j_r) begin
            if (last_j) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end
        end
        pobp_pkg::ST_KSET: begin
          li_r <= len_i_r;
          k_r <= (len_i_r < len_j_r) ? len_i_r : len_j_r;
          t_r <= '0;
        end
        pobp_pkg::ST_RDREQ: ;
        pobp_pkg::ST_CMP: begin
          if (ovl_settled) begin
            // overlap of this pair found (k_r, or zero)
            if (best_none_r || {1'b0, k_r} > best_r) begin
              best_r <= {1'b0, k_r};
              best_none_r <= 1'b0;
              bi_r <= i_r;
              bj_r <= j_r;
            end
            if (last_j) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end else if (rd_a_r == rd_b_r) begin
            t_r <= t_r + 1'b1;
          end else begin
            k_r <= k_r - 1'b1;
            t_r <= '0;
          end
        end
        pobp_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          out_pair_found <= (count_r >= CW'(2));
          out_best_overlap <= (count_r >= CW'(2)) ? pobp_pkg::OVL_W'(best_r) : '0;
          out_first_word <= (count_r >= CW'(2)) ? pobp_pkg::IDX_W'(bi_r) : '0;
          out_second_word <= (count_r >= CW'(2)) ? pobp_pkg::IDX_W'(bj_r) : '0;
          out_overflow <= ovf_r;
          count_r <= '0;
          pos_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
